// ----- design/debounced_fill_pump_controller_defines.svh -----
// Assertion macros shared by the fill pump controller RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef DEBOUNCED_FILL_PUMP_CONTROLLER_DEFINES_SVH
`define DEBOUNCED_FILL_PUMP_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define DFPC_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fill pump controller: invariant violated");
// Condition that must hold in the cycle after the antecedent.
`define DFPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fill pump controller: next-cycle check failed");
`else
`define DFPC_ASSERT(label, clk, rst, expr)
`define DFPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/dfp_pkg.sv -----
`default_nettype none

package dfp_pkg;

   // Default parameter values.
   localparam int TIME_BITS_DEF   = 48;
   localparam int STREAK_BITS_DEF = 8;

   localparam int CONFIRM_BITS = 8;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_STEP       = 2'd0;
   localparam logic [1:0] OP_DRIVER_ERR = 2'd1;
   localparam logic [1:0] OP_RESTART    = 2'd2;

   // Level sample codes; anything else reads as unknown.
   localparam logic [1:0] LEVEL_WET = 2'd1;
   localparam logic [1:0] LEVEL_DRY = 2'd2;

   // Stop cause codes.
   localparam logic [2:0] CAUSE_NONE    = 3'd0;
   localparam logic [2:0] CAUSE_TIMEOUT = 3'd1;
   localparam logic [2:0] CAUSE_UNKNOWN = 3'd2;
   localparam logic [2:0] CAUSE_WET     = 3'd3;
   localparam logic [2:0] CAUSE_DRIVER  = 3'd4;

   // Register indexes on the CSR port.
   localparam logic [1:0] REG_MAX_RUN    = 2'd0;
   localparam logic [1:0] REG_MIN_REST   = 2'd1;
   localparam logic [1:0] REG_DRY_CONFIRM = 2'd2;
   localparam logic [1:0] REG_WET_CONFIRM = 2'd3;

   localparam logic [31:0] MAX_RUN_RESET  = 32'd60000;
   localparam logic [31:0] MIN_REST_RESET = 32'd30000;
   localparam logic [7:0]  DRY_CONFIRM_RESET = 8'd3;
   localparam logic [7:0]  WET_CONFIRM_RESET = 8'd3;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Response word: 75 field bits padded to whole bytes.
   localparam int RSP_FIELD_BITS = 75;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [31:0]             max_run_ms;
      logic [31:0]             min_rest_ms;
      logic [CONFIRM_BITS-1:0] dry_confirm_count;
      logic [CONFIRM_BITS-1:0] wet_confirm_count;
   } cfg_type;

   typedef struct packed {
      logic        switch_on;
      logic        switch_off;
      logic [2:0]  stop_cause;
      logic        running;
      logic        level_valid;
      logic        tank_full;
      logic [31:0] rest_left_ms;
      logic [31:0] timeout_total;
      logic [2:0]  last_cause;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/dfp_core.sv -----
`default_nettype none
`include "debounced_fill_pump_controller_defines.svh"

// Controller state and the single-pass update for one word.
module dfp_core #(
   parameter int TIME_BITS   = dfp_pkg::TIME_BITS_DEF,
   parameter int STREAK_BITS = dfp_pkg::STREAK_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   fire,
   input  wire  [1:0]            op,
   input  wire  [1:0]            sensor_level,
   input  wire  [TIME_BITS-1:0]  time_now,
   input  wire                   forced_timeout,
   input  wire  [2:0]            restart_reason,
   input  dfp_pkg::cfg_type      cfg,
   output dfp_pkg::rsp_type      result
);

   localparam int CNT_BITS = (STREAK_BITS > dfp_pkg::CONFIRM_BITS) ?
                             STREAK_BITS : dfp_pkg::CONFIRM_BITS;
   localparam logic [STREAK_BITS-1:0] STREAK_MAX = {STREAK_BITS{1'b1}};

   logic                   run_ff, run_in;
   logic [STREAK_BITS-1:0] wet_ff, wet_in;
   logic [STREAK_BITS-1:0] dry_ff, dry_in;
   logic                   known_ff, known_in;
   logic                   full_ff, full_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   stop_ff, stop_in;
   logic [2:0]             last_ff, last_in;
   logic [31:0]            tally_ff, tally_in;

   logic                   regs_ok;
   logic                   unknown;
   logic                   stopped;
   logic [TIME_BITS-1:0]   ran;
   logic [TIME_BITS-1:0]   elapsed;
   logic [STREAK_BITS-1:0] wet_bump;
   logic [STREAK_BITS-1:0] dry_bump;
   logic                   sw_on, sw_off;
   logic [2:0]             cause;
   logic [31:0]            rest_left;

   always_comb begin
      regs_ok = (cfg.max_run_ms != '0) && (cfg.min_rest_ms != '0) &&
                (cfg.dry_confirm_count != '0) && (cfg.wet_confirm_count != '0);
      ran     = time_now - start_ff;
      elapsed = time_now - stop_ff;

      // Streaks saturate at the confirm count and at the counter's top value.
      wet_bump = wet_ff;
      if ((CNT_BITS'(wet_ff) < CNT_BITS'(cfg.wet_confirm_count)) && (wet_ff != STREAK_MAX)) begin
         wet_bump = wet_ff + STREAK_BITS'(1);
      end
      dry_bump = dry_ff;
      if ((CNT_BITS'(dry_ff) < CNT_BITS'(cfg.dry_confirm_count)) && (dry_ff != STREAK_MAX)) begin
         dry_bump = dry_ff + STREAK_BITS'(1);
      end

      run_in   = run_ff;
      wet_in   = wet_ff;
      dry_in   = dry_ff;
      known_in = known_ff;
      full_in  = full_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      last_in  = last_ff;
      tally_in = tally_ff;
      unknown  = 1'b0;
      stopped  = 1'b0;
      sw_on    = 1'b0;
      sw_off   = 1'b0;
      cause    = dfp_pkg::CAUSE_NONE;

      case (op)
         dfp_pkg::OP_DRIVER_ERR: begin
            sw_off  = run_ff;
            cause   = dfp_pkg::CAUSE_DRIVER;
            run_in  = 1'b0;
            stop_in = time_now;
            last_in = dfp_pkg::CAUSE_DRIVER;
            stopped = 1'b1;
         end
         dfp_pkg::OP_RESTART: begin
            if (regs_ok) begin
               run_in   = 1'b0;
               wet_in   = '0;
               dry_in   = '0;
               known_in = 1'b0;
               full_in  = 1'b0;
               start_in = '0;
               tally_in = '0;
               stop_in  = time_now;
               last_in  = (restart_reason <= dfp_pkg::CAUSE_DRIVER) ?
                          restart_reason : dfp_pkg::CAUSE_NONE;
               stopped  = 1'b1;
            end
         end
         dfp_pkg::OP_STEP: begin
            if (regs_ok) begin
               case (sensor_level)
                  dfp_pkg::LEVEL_WET: begin
                     wet_in = wet_bump;
                     dry_in = '0;
                  end
                  dfp_pkg::LEVEL_DRY: begin
                     dry_in = dry_bump;
                     wet_in = '0;
                  end
                  default: begin
                     unknown  = 1'b1;
                     wet_in   = '0;
                     dry_in   = '0;
                     known_in = 1'b0;
                  end
               endcase
               if (CNT_BITS'(wet_in) >= CNT_BITS'(cfg.wet_confirm_count)) begin
                  full_in  = 1'b1;
                  known_in = 1'b1;
               end
               if (CNT_BITS'(dry_in) >= CNT_BITS'(cfg.dry_confirm_count)) begin
                  full_in  = 1'b0;
                  known_in = 1'b1;
               end
               if (run_ff) begin
                  if (forced_timeout || (ran >= TIME_BITS'(cfg.max_run_ms))) begin
                     cause    = dfp_pkg::CAUSE_TIMEOUT;
                     tally_in = tally_ff + 32'd1;
                  end else if (unknown) begin
                     cause = dfp_pkg::CAUSE_UNKNOWN;
                  end else if (known_in && full_in) begin
                     cause = dfp_pkg::CAUSE_WET;
                  end
                  if (cause != dfp_pkg::CAUSE_NONE) begin
                     sw_off  = 1'b1;
                     run_in  = 1'b0;
                     stop_in = time_now;
                     last_in = cause;
                     stopped = 1'b1;
                  end
               end else if (!unknown && known_in && !full_in &&
                            (CNT_BITS'(dry_in) >= CNT_BITS'(cfg.dry_confirm_count)) &&
                            (elapsed >= TIME_BITS'(cfg.min_rest_ms))) begin
                  run_in   = 1'b1;
                  start_in = time_now;
                  sw_on    = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // A stop recorded by this word puts the stop time at time_now.
      if (stopped || (time_now <= stop_ff)) begin
         rest_left = cfg.min_rest_ms;
      end else if (elapsed >= TIME_BITS'(cfg.min_rest_ms)) begin
         rest_left = '0;
      end else begin
         rest_left = cfg.min_rest_ms - elapsed[31:0];
      end
   end

   always_comb begin
      result.switch_on     = sw_on;
      result.switch_off    = sw_off;
      result.stop_cause    = cause;
      result.running       = run_in;
      result.level_valid   = known_in;
      result.tank_full     = full_in;
      result.rest_left_ms  = rest_left;
      result.timeout_total = tally_in;
      result.last_cause    = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         wet_ff   <= '0;
         dry_ff   <= '0;
         known_ff <= 1'b0;
         full_ff  <= 1'b0;
         start_ff <= '0;
         stop_ff  <= '0;
         last_ff  <= dfp_pkg::CAUSE_NONE;
         tally_ff <= '0;
      end else if (fire) begin
         run_ff   <= run_in;
         wet_ff   <= wet_in;
         dry_ff   <= dry_in;
         known_ff <= known_in;
         full_ff  <= full_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         last_ff  <= last_in;
         tally_ff <= tally_in;
      end
   end

   `DFPC_ASSERT(a_streak_exclusive, clock, reset, (wet_ff == '0) || (dry_ff == '0))
   `DFPC_ASSERT_NEXT(a_on_starts, clock, reset, fire && sw_on, run_ff && (start_ff == $past(time_now)))
   `DFPC_ASSERT_NEXT(a_off_stops, clock, reset, fire && sw_off, !run_ff && (stop_ff == $past(time_now)))
   `DFPC_ASSERT_NEXT(a_timeout_counts, clock, reset, fire && (cause == dfp_pkg::CAUSE_TIMEOUT), tally_ff == ($past(tally_ff) + 32'd1))

endmodule

`default_nettype wire

// ----- design/debounced_fill_pump_controller.sv -----
// Debounced fill pump controller.
// Request channel (req_*): one word per operation. tuser carries the operation
// (step, driver error notice, restart); tdata carries the level sample, the
// millisecond timestamp, the forced timeout flag and the restart reason.
// Response channel (rsp_*): exactly one word per request word, in order, with
// the on/off command, the stop cause and the controller status after the word.
// CSR port: APB-style, four registers at byte addresses 0, 4, 8 and 12 (32-bit
// max run and min rest, 8-bit dry and wet confirm counts); write only while
// no request word is in flight.
// A word in the request register passes through one combinational update into the
// response register. Throughput is one word per cycle while the response register
// is not held by a low rsp_tready, set by that single combinational update.
// A full response register holds its word while rsp_tready is low; the request
// register can still take one word, and req_tready drops only once both hold.
// Reset clears the controller state, empties both registers and loads the
// register defaults.
`default_nettype none

module debounced_fill_pump_controller #(
   parameter int TIME_BITS   = dfp_pkg::TIME_BITS_DEF,
   parameter int STREAK_BITS = dfp_pkg::STREAK_BITS_DEF,
   localparam int REQ_FIELD_BITS = TIME_BITS + 6,
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8
) (
   input  wire                               clock,
   input  wire                               reset,
   // Request word channel.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // Low bit up: sensor_level[1:0], time_now, forced_timeout, restart_reason[2:0],
   // zero padding.
   input  wire  [REQ_TDATA_BITS-1:0]         req_tdata,
   // op[1:0].
   input  wire  [1:0]                        req_tuser,
   // Response word channel.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // Low bit up: switch_on, switch_off, stop_cause[2:0], running, level_valid,
   // tank_full, rest_left_ms[31:0], timeout_total[31:0], last_cause[2:0],
   // zero padding.
   output logic [dfp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // Register port.
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [dfp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [dfp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dfp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int RSP_PAD_BITS = dfp_pkg::RSP_TDATA_BITS - dfp_pkg::RSP_FIELD_BITS;

   // Configuration registers.
   dfp_pkg::cfg_type cfg_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   // Request register.
   logic                 in_valid_ff;
   logic [1:0]           op_ff;
   logic [1:0]           level_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 forced_ff;
   logic [2:0]           reason_ff;

   // Response register.
   logic             rsp_valid_ff;
   dfp_pkg::rsp_type rsp_ff;
   dfp_pkg::rsp_type result;

   logic advance;
   logic fire;
   logic req_take;

   // The CSR port never waits; a write lands on the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_run_ms        <= dfp_pkg::MAX_RUN_RESET;
         cfg_ff.min_rest_ms       <= dfp_pkg::MIN_REST_RESET;
         cfg_ff.dry_confirm_count <= dfp_pkg::DRY_CONFIRM_RESET;
         cfg_ff.wet_confirm_count <= dfp_pkg::WET_CONFIRM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dfp_pkg::REG_MAX_RUN:     cfg_ff.max_run_ms  <= csr_pwdata;
            dfp_pkg::REG_MIN_REST:    cfg_ff.min_rest_ms <= csr_pwdata;
            dfp_pkg::REG_DRY_CONFIRM: begin
               cfg_ff.dry_confirm_count <= csr_pwdata[dfp_pkg::CONFIRM_BITS-1:0];
            end
            dfp_pkg::REG_WET_CONFIRM: begin
               cfg_ff.wet_confirm_count <= csr_pwdata[dfp_pkg::CONFIRM_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dfp_pkg::REG_MAX_RUN:     csr_prdata = cfg_ff.max_run_ms;
         dfp_pkg::REG_MIN_REST:    csr_prdata = cfg_ff.min_rest_ms;
         dfp_pkg::REG_DRY_CONFIRM: csr_prdata = 32'(cfg_ff.dry_confirm_count);
         dfp_pkg::REG_WET_CONFIRM: csr_prdata = 32'(cfg_ff.wet_confirm_count);
         default:                  csr_prdata = '0;
      endcase
   end

   // The response register moves whenever it is empty or being drained, and the
   // request register refills in the same cycle it hands its word over.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_tuser;
         level_ff  <= req_tdata[1:0];
         time_ff   <= req_tdata[TIME_BITS+1:2];
         forced_ff <= req_tdata[TIME_BITS+2];
         reason_ff <= req_tdata[TIME_BITS+5:TIME_BITS+3];
      end
   end

   dfp_core #(
      .TIME_BITS   (TIME_BITS),
      .STREAK_BITS (STREAK_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .op             (op_ff),
      .sensor_level   (level_ff),
      .time_now       (time_ff),
      .forced_timeout (forced_ff),
      .restart_reason (reason_ff),
      .cfg            (cfg_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}},
                        rsp_ff.last_cause,
                        rsp_ff.timeout_total,
                        rsp_ff.rest_left_ms,
                        rsp_ff.tank_full,
                        rsp_ff.level_valid,
                        rsp_ff.running,
                        rsp_ff.stop_cause,
                        rsp_ff.switch_off,
                        rsp_ff.switch_on};

endmodule

`default_nettype wire
